@@ src/sfr_pkg.sv @@
// Shared types and constants of the serial frame receiver.
package sfr_pkg;

   localparam int unsigned HEADER_BYTES = 4;

   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 16;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_OWN_ADDRESS   = 3'd0,
      CSR_ALT_ADDRESS   = 3'd1,
      CSR_PORT_KIND     = 3'd2,
      CSR_START_BYTE    = 3'd3,
      CSR_END_BYTE      = 3'd4,
      CSR_MAX_FRAME_LEN = 3'd5,
      CSR_BIG_ENDIAN    = 3'd6,
      CSR_CHAR_TIMEOUT  = 3'd7
   } csr_index_type;

   typedef enum logic [1:0] {
      CMD_BYTE     = 2'd0,
      CMD_TICK     = 2'd1,
      CMD_TIMEOUT  = 2'd2,
      CMD_EXT_SYNC = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_ERROR   = 2'd1,
      STATUS_TIMEOUT = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      CAUSE_NONE      = 3'd0,
      CAUSE_BAD_LEN   = 3'd1,
      CAUSE_DATA_TMO  = 3'd2,
      CAUSE_NO_END    = 3'd3,
      CAUSE_CHECKSUM  = 3'd4,
      CAUSE_ADDRESS   = 3'd5,
      CAUSE_FRAME_TMO = 3'd6
   } cause_type;

   localparam logic KIND_DATA    = 1'b0;
   localparam logic KIND_VERDICT = 1'b1;

   typedef enum logic [8:0] {
      PH_HUNT = 9'b000000001,
      PH_ADDR = 9'b000000010,
      PH_LEN0 = 9'b000000100,
      PH_LEN1 = 9'b000001000,
      PH_OPC  = 9'b000010000,
      PH_DATA = 9'b000100000,
      PH_CK0  = 9'b001000000,
      PH_CK1  = 9'b010000000,
      PH_END  = 9'b100000000
   } phase_type;

   typedef struct packed {
      logic [7:0]  own_address;
      logic [7:0]  alt_address;
      logic        port_kind;
      logic [7:0]  start_byte;
      logic [7:0]  end_byte;
      logic [15:0] max_frame_length;
      logic        big_endian;
      logic [15:0] char_timeout_ticks;
   } cfg_type;

   typedef struct packed {
      logic        kind;
      logic [7:0]  data_byte;
      logic [15:0] byte_index;
      logic [1:0]  status;
      logic [2:0]  cause;
      logic [7:0]  frame_address;
      logic [7:0]  opcode;
      logic [15:0] data_length;
   } rsp_type;

endpackage

@@ src/sfr_req_if.sv @@
// Input channel: received bytes and events.
interface sfr_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] command;
   logic [7:0] rx_byte;

   modport source (output valid, output command, output rx_byte, input ready);
   modport sink   (input valid, input command, input rx_byte, output ready);
endinterface

@@ src/sfr_rsp_if.sv @@
// Result channel: payload bytes and frame verdicts.
interface sfr_rsp_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [7:0]  data_byte;
   logic [15:0] byte_index;
   logic [1:0]  status;
   logic [2:0]  cause;
   logic [7:0]  frame_address;
   logic [7:0]  opcode;
   logic [15:0] data_length;

   modport source (output valid, output kind, output data_byte, output byte_index,
                   output status, output cause, output frame_address, output opcode,
                   output data_length, input ready);
   modport sink   (input valid, input kind, input data_byte, input byte_index,
                   input status, input cause, input frame_address, input opcode,
                   input data_length, output ready);
endinterface

@@ src/serial_frame_receiver_top.sv @@
// Top level of the serial frame receiver: framing state machine and result register.
//
// The receiver takes one beat per clock (byte, tick, overall timeout or external
// start) and streams out payload bytes and frame verdicts. Each beat is
// captured in an input register, the frame state and at most one result are
// computed from it combinationally, and the result is registered in an output
// register before it is presented on the result channel. Beats that
// produce no result go through even while a result waits on the output; a beat that
// does produce one waits only for the output register to drain. Configuration
// registers are written through the csr_ port and take effect at once; write them
// only while no frame is in flight.
module serial_frame_receiver_top (
   input  logic                             clock,
   input  logic                             reset,
   sfr_req_if.sink                          req_chan,
   sfr_rsp_if.source                        rsp_chan,
   input  logic                             csr_we,
   input  logic [sfr_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [sfr_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam logic [15:0] HDR = 16'(sfr_pkg::HEADER_BYTES);

   sfr_pkg::cfg_type cfg;

   sfr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // input register
   logic       in_valid_ff;
   logic [1:0] in_cmd_ff;
   logic [7:0] in_byte_ff;

   // frame state
   sfr_pkg::phase_type phase_ff, phase_in;
   logic [7:0]  held_address_ff, held_address_in;
   logic [15:0] held_length_ff, held_length_in;
   logic [7:0]  held_opcode_ff, held_opcode_in;
   logic [15:0] bytes_left_ff, bytes_left_in;
   logic [15:0] running_sum_ff, running_sum_in;
   logic [15:0] received_sum_ff, received_sum_in;
   logic [15:0] idle_ticks_ff, idle_ticks_in;

   // output register
   logic             out_valid_ff;
   sfr_pkg::rsp_type out_ff;
   sfr_pkg::rsp_type rsp_in;
   logic             produce;
   logic             advance;

   logic [15:0] payload_len;
   logic [15:0] limit;
   logic [15:0] idle_inc;
   logic [15:0] joined;
   logic [15:0] sum_plus;
   logic        addr_ok;

   assign payload_len = held_length_ff - HDR;
   assign limit       = (cfg.char_timeout_ticks == 16'd0) ? 16'd1 : cfg.char_timeout_ticks;
   assign idle_inc    = (idle_ticks_ff == 16'hFFFF) ? idle_ticks_ff : idle_ticks_ff + 16'd1;
   assign sum_plus    = running_sum_ff + {8'd0, in_byte_ff};
   assign addr_ok     = (held_address_ff == cfg.own_address) ||
                        (!cfg.port_kind && cfg.alt_address != 8'd0 &&
                         held_address_ff == cfg.alt_address);

   // first byte of a two-byte field sits in the low half of the held register
   always_comb begin
      logic [7:0] first;
      first  = (phase_ff == sfr_pkg::PH_LEN1) ? held_length_ff[7:0] : received_sum_ff[7:0];
      joined = cfg.big_endian ? {first, in_byte_ff} : {in_byte_ff, first};
   end

   always_comb begin
      phase_in        = phase_ff;
      held_address_in = held_address_ff;
      held_length_in  = held_length_ff;
      held_opcode_in  = held_opcode_ff;
      bytes_left_in   = bytes_left_ff;
      running_sum_in  = running_sum_ff;
      received_sum_in = received_sum_ff;
      idle_ticks_in   = idle_ticks_ff;
      produce         = 1'b0;
      rsp_in          = '0;
      rsp_in.kind          = sfr_pkg::KIND_VERDICT;
      rsp_in.frame_address = held_address_ff;
      rsp_in.opcode        = held_opcode_ff;
      rsp_in.data_length   = payload_len;

      case (sfr_pkg::cmd_type'(in_cmd_ff))
         sfr_pkg::CMD_EXT_SYNC: begin
            phase_in        = sfr_pkg::PH_ADDR;
            held_address_in = '0;
            held_length_in  = '0;
            held_opcode_in  = '0;
            bytes_left_in   = '0;
            running_sum_in  = '0;
            received_sum_in = '0;
            idle_ticks_in   = '0;
         end
         sfr_pkg::CMD_TIMEOUT: begin
            if (phase_ff == sfr_pkg::PH_HUNT) begin
               produce              = 1'b1;
               rsp_in.status        = sfr_pkg::STATUS_TIMEOUT;
               rsp_in.cause         = sfr_pkg::CAUSE_FRAME_TMO;
               rsp_in.frame_address = '0;
               rsp_in.opcode        = '0;
               rsp_in.data_length   = '0;
               idle_ticks_in        = '0;
            end
         end
         sfr_pkg::CMD_TICK: begin
            if (phase_ff != sfr_pkg::PH_HUNT) begin
               idle_ticks_in = idle_inc;
               if (idle_inc >= limit) begin
                  phase_in      = sfr_pkg::PH_HUNT;
                  idle_ticks_in = '0;
                  if (phase_ff == sfr_pkg::PH_DATA) begin
                     produce       = 1'b1;
                     rsp_in.status = sfr_pkg::STATUS_TIMEOUT;
                     rsp_in.cause  = sfr_pkg::CAUSE_DATA_TMO;
                  end
               end
            end
         end
         default: begin
            // received byte
            if (phase_ff != sfr_pkg::PH_HUNT) begin
               idle_ticks_in = '0;
            end
            case (phase_ff)
               sfr_pkg::PH_HUNT: begin
                  if (in_byte_ff == cfg.start_byte) begin
                     phase_in        = sfr_pkg::PH_ADDR;
                     held_address_in = '0;
                     held_length_in  = '0;
                     held_opcode_in  = '0;
                     bytes_left_in   = '0;
                     running_sum_in  = '0;
                     received_sum_in = '0;
                     idle_ticks_in   = '0;
                  end
               end
               sfr_pkg::PH_ADDR: begin
                  held_address_in = in_byte_ff;
                  running_sum_in  = {8'd0, in_byte_ff};
                  phase_in        = sfr_pkg::PH_LEN0;
               end
               sfr_pkg::PH_LEN0: begin
                  held_length_in = {8'd0, in_byte_ff};
                  running_sum_in = sum_plus;
                  phase_in       = sfr_pkg::PH_LEN1;
               end
               sfr_pkg::PH_LEN1: begin
                  running_sum_in = sum_plus;
                  held_length_in = joined;
                  if (joined > cfg.max_frame_length || joined < HDR) begin
                     produce            = 1'b1;
                     rsp_in.status      = sfr_pkg::STATUS_ERROR;
                     rsp_in.cause       = sfr_pkg::CAUSE_BAD_LEN;
                     rsp_in.opcode      = '0;
                     rsp_in.data_length = '0;
                     phase_in           = sfr_pkg::PH_HUNT;
                  end else begin
                     phase_in = sfr_pkg::PH_OPC;
                  end
               end
               sfr_pkg::PH_OPC: begin
                  held_opcode_in = in_byte_ff;
                  running_sum_in = sum_plus;
                  bytes_left_in  = payload_len;
                  phase_in       = (payload_len != 16'd0) ? sfr_pkg::PH_DATA : sfr_pkg::PH_CK0;
               end
               sfr_pkg::PH_DATA: begin
                  produce           = 1'b1;
                  rsp_in.kind       = sfr_pkg::KIND_DATA;
                  rsp_in.data_byte  = in_byte_ff;
                  rsp_in.byte_index = payload_len - bytes_left_ff;
                  running_sum_in    = sum_plus;
                  bytes_left_in     = bytes_left_ff - 16'd1;
                  if (bytes_left_ff == 16'd1) begin
                     phase_in = sfr_pkg::PH_CK0;
                  end
               end
               sfr_pkg::PH_CK0: begin
                  received_sum_in = {8'd0, in_byte_ff};
                  phase_in        = sfr_pkg::PH_CK1;
               end
               sfr_pkg::PH_CK1: begin
                  received_sum_in = joined;
                  phase_in        = sfr_pkg::PH_END;
               end
               sfr_pkg::PH_END: begin
                  produce  = 1'b1;
                  phase_in = sfr_pkg::PH_HUNT;
                  if (in_byte_ff != cfg.end_byte) begin
                     rsp_in.status = sfr_pkg::STATUS_ERROR;
                     rsp_in.cause  = sfr_pkg::CAUSE_NO_END;
                  end else if (received_sum_ff != running_sum_ff) begin
                     rsp_in.status = sfr_pkg::STATUS_ERROR;
                     rsp_in.cause  = sfr_pkg::CAUSE_CHECKSUM;
                  end else if (!addr_ok) begin
                     rsp_in.status = sfr_pkg::STATUS_ERROR;
                     rsp_in.cause  = sfr_pkg::CAUSE_ADDRESS;
                  end else begin
                     rsp_in.status = sfr_pkg::STATUS_OK;
                     rsp_in.cause  = sfr_pkg::CAUSE_NONE;
                  end
               end
               default: begin
                  phase_in = sfr_pkg::PH_HUNT;
               end
            endcase
         end
      endcase
   end

   // a beat with no result never waits on the output register
   assign advance = in_valid_ff && (!produce || !out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready && req_chan.valid) begin
         in_cmd_ff  <= req_chan.command;
         in_byte_ff <= req_chan.rx_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= sfr_pkg::PH_HUNT;
         held_address_ff <= '0;
         held_length_ff  <= '0;
         held_opcode_ff  <= '0;
         bytes_left_ff   <= '0;
         running_sum_ff  <= '0;
         received_sum_ff <= '0;
         idle_ticks_ff   <= '0;
      end else if (advance) begin
         phase_ff        <= phase_in;
         held_address_ff <= held_address_in;
         held_length_ff  <= held_length_in;
         held_opcode_ff  <= held_opcode_in;
         bytes_left_ff   <= bytes_left_in;
         running_sum_ff  <= running_sum_in;
         received_sum_ff <= received_sum_in;
         idle_ticks_ff   <= idle_ticks_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance && produce) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && produce) begin
         out_ff <= rsp_in;
      end
   end

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.kind          = out_ff.kind;
   assign rsp_chan.data_byte     = out_ff.data_byte;
   assign rsp_chan.byte_index    = out_ff.byte_index;
   assign rsp_chan.status        = out_ff.status;
   assign rsp_chan.cause         = out_ff.cause;
   assign rsp_chan.frame_address = out_ff.frame_address;
   assign rsp_chan.opcode        = out_ff.opcode;
   assign rsp_chan.data_length   = out_ff.data_length;

endmodule

@@ src/sfr_csr.sv @@
// Configuration register file of the serial frame receiver.
module sfr_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [sfr_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [sfr_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output sfr_pkg::cfg_type                 cfg
);

   sfr_pkg::cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (sfr_pkg::csr_index_type'(csr_index))
            sfr_pkg::CSR_OWN_ADDRESS:   cfg_in.own_address        = csr_wdata[7:0];
            sfr_pkg::CSR_ALT_ADDRESS:   cfg_in.alt_address        = csr_wdata[7:0];
            sfr_pkg::CSR_PORT_KIND:     cfg_in.port_kind          = csr_wdata[0];
            sfr_pkg::CSR_START_BYTE:    cfg_in.start_byte         = csr_wdata[7:0];
            sfr_pkg::CSR_END_BYTE:      cfg_in.end_byte           = csr_wdata[7:0];
            sfr_pkg::CSR_MAX_FRAME_LEN: cfg_in.max_frame_length   = csr_wdata;
            sfr_pkg::CSR_BIG_ENDIAN:    cfg_in.big_endian         = csr_wdata[0];
            sfr_pkg::CSR_CHAR_TIMEOUT:  cfg_in.char_timeout_ticks = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.own_address        <= 8'd1;
         cfg_ff.alt_address        <= 8'd0;
         cfg_ff.port_kind          <= 1'b0;
         cfg_ff.start_byte         <= 8'd2;
         cfg_ff.end_byte           <= 8'd3;
         cfg_ff.max_frame_length   <= 16'd255;
         cfg_ff.big_endian         <= 1'b0;
         cfg_ff.char_timeout_ticks <= 16'd1000;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ tb/tb_serial_frame_receiver_top.sv @@
// Serial frame receiver testbench: directed and random framed traffic checked by a predictor.
`timescale 1ns / 1ps

module tb_serial_frame_receiver_top;

   typedef struct packed {
      sfr_pkg::cmd_type cmd;
      logic [7:0]       data;
   } rx_beat_type;

   class frame_scoreboard;
      sfr_pkg::cfg_type   cfg;
      sfr_pkg::phase_type phase;
      logic [7:0]  held_address;
      logic [15:0] held_length;
      logic [7:0]  held_opcode;
      logic [15:0] bytes_left;
      logic [15:0] running_sum;
      logic [15:0] received_sum;
      logic [15:0] idle_ticks;
      sfr_pkg::rsp_type awaited_results[$];
      int          errors;
      int          beats_in;
      int          payload_seen;
      int          cause_seen[7];

      function new();
         cfg.own_address        = 8'd1;
         cfg.alt_address        = 8'd0;
         cfg.port_kind          = 1'b0;
         cfg.start_byte         = 8'd2;
         cfg.end_byte           = 8'd3;
         cfg.max_frame_length   = 16'd255;
         cfg.big_endian         = 1'b0;
         cfg.char_timeout_ticks = 16'd1000;
         phase        = sfr_pkg::PH_HUNT;
         held_address = '0;
         held_length  = '0;
         held_opcode  = '0;
         bytes_left   = '0;
         running_sum  = '0;
         received_sum = '0;
         idle_ticks   = '0;
         errors       = 0;
         beats_in     = 0;
         payload_seen = 0;
         foreach (cause_seen[i]) cause_seen[i] = 0;
      endfunction

      function void apply_csr(sfr_pkg::csr_index_type idx, logic [15:0] v);
         case (idx)
            sfr_pkg::CSR_OWN_ADDRESS:   cfg.own_address        = v[7:0];
            sfr_pkg::CSR_ALT_ADDRESS:   cfg.alt_address        = v[7:0];
            sfr_pkg::CSR_PORT_KIND:     cfg.port_kind          = v[0];
            sfr_pkg::CSR_START_BYTE:    cfg.start_byte         = v[7:0];
            sfr_pkg::CSR_END_BYTE:      cfg.end_byte           = v[7:0];
            sfr_pkg::CSR_MAX_FRAME_LEN: cfg.max_frame_length   = v;
            sfr_pkg::CSR_BIG_ENDIAN:    cfg.big_endian         = v[0];
            sfr_pkg::CSR_CHAR_TIMEOUT:  cfg.char_timeout_ticks = v;
            default: ;
         endcase
      endfunction

      function logic [15:0] join16(logic [7:0] first, logic [7:0] second);
         return cfg.big_endian ? {first, second} : {second, first};
      endfunction

      function logic [15:0] payload_len();
         return 16'(held_length - sfr_pkg::HEADER_BYTES);
      endfunction

      function void begin_frame();
         phase        = sfr_pkg::PH_ADDR;
         idle_ticks   = '0;
         running_sum  = '0;
         received_sum = '0;
         bytes_left   = '0;
         held_address = '0;
         held_length  = '0;
         held_opcode  = '0;
      endfunction

      function void push_verdict(sfr_pkg::status_type st, sfr_pkg::cause_type cs,
                                 logic [7:0] addr, logic [7:0] opc, logic [15:0] len);
         sfr_pkg::rsp_type r;
         r               = '0;
         r.kind          = sfr_pkg::KIND_VERDICT;
         r.status        = st;
         r.cause         = cs;
         r.frame_address = addr;
         r.opcode        = opc;
         r.data_length   = len;
         awaited_results.push_back(r);
         phase      = sfr_pkg::PH_HUNT;
         idle_ticks = '0;
      endfunction

      function bit address_ok();
         if (held_address == cfg.own_address) return 1'b1;
         return cfg.port_kind == 1'b0 && cfg.alt_address != 8'd0 &&
                held_address == cfg.alt_address;
      endfunction

      // Deframing step for one accepted input beat.
      function void take_rx_beat(sfr_pkg::cmd_type c, logic [7:0] b);
         logic [15:0]      limit;
         sfr_pkg::rsp_type r;
         beats_in++;
         if (c == sfr_pkg::CMD_EXT_SYNC) begin
            begin_frame();
            return;
         end
         if (c == sfr_pkg::CMD_TIMEOUT) begin
            if (phase == sfr_pkg::PH_HUNT)
               push_verdict(sfr_pkg::STATUS_TIMEOUT, sfr_pkg::CAUSE_FRAME_TMO, 8'd0, 8'd0,
                            16'd0);
            return;
         end
         if (c == sfr_pkg::CMD_TICK) begin
            limit = (cfg.char_timeout_ticks == 0) ? 16'd1 : cfg.char_timeout_ticks;
            if (phase == sfr_pkg::PH_HUNT) return;
            if (idle_ticks != 16'hFFFF) idle_ticks++;
            if (idle_ticks < limit) return;
            if (phase == sfr_pkg::PH_DATA) begin
               push_verdict(sfr_pkg::STATUS_TIMEOUT, sfr_pkg::CAUSE_DATA_TMO, held_address,
                            held_opcode, payload_len());
            end else begin
               phase      = sfr_pkg::PH_HUNT;
               idle_ticks = '0;
            end
            return;
         end
         if (phase == sfr_pkg::PH_HUNT) begin
            if (b == cfg.start_byte) begin_frame();
            return;
         end
         idle_ticks = '0;
         case (phase)
            sfr_pkg::PH_ADDR: begin
               held_address = b;
               running_sum  = 16'(b);
               phase        = sfr_pkg::PH_LEN0;
            end
            sfr_pkg::PH_LEN0: begin
               held_length = 16'(b);
               running_sum = running_sum + 16'(b);
               phase       = sfr_pkg::PH_LEN1;
            end
            sfr_pkg::PH_LEN1: begin
               running_sum = running_sum + 16'(b);
               held_length = join16(held_length[7:0], b);
               if (held_length > cfg.max_frame_length ||
                   held_length < sfr_pkg::HEADER_BYTES) begin
                  push_verdict(sfr_pkg::STATUS_ERROR, sfr_pkg::CAUSE_BAD_LEN, held_address,
                               8'd0, 16'd0);
               end else begin
                  phase = sfr_pkg::PH_OPC;
               end
            end
            sfr_pkg::PH_OPC: begin
               held_opcode = b;
               running_sum = running_sum + 16'(b);
               bytes_left  = payload_len();
               phase       = (bytes_left != 0) ? sfr_pkg::PH_DATA : sfr_pkg::PH_CK0;
            end
            sfr_pkg::PH_DATA: begin
               r               = '0;
               r.kind          = sfr_pkg::KIND_DATA;
               r.data_byte     = b;
               r.byte_index    = payload_len() - bytes_left;
               r.frame_address = held_address;
               r.opcode        = held_opcode;
               r.data_length   = payload_len();
               awaited_results.push_back(r);
               running_sum = running_sum + 16'(b);
               bytes_left  = bytes_left - 16'd1;
               if (bytes_left == 0) phase = sfr_pkg::PH_CK0;
            end
            sfr_pkg::PH_CK0: begin
               received_sum = 16'(b);
               phase        = sfr_pkg::PH_CK1;
            end
            sfr_pkg::PH_CK1: begin
               received_sum = join16(received_sum[7:0], b);
               phase        = sfr_pkg::PH_END;
            end
            sfr_pkg::PH_END: begin
               if (b != cfg.end_byte)
                  push_verdict(sfr_pkg::STATUS_ERROR, sfr_pkg::CAUSE_NO_END, held_address,
                               held_opcode, payload_len());
               else if (received_sum != running_sum)
                  push_verdict(sfr_pkg::STATUS_ERROR, sfr_pkg::CAUSE_CHECKSUM, held_address,
                               held_opcode, payload_len());
               else if (!address_ok())
                  push_verdict(sfr_pkg::STATUS_ERROR, sfr_pkg::CAUSE_ADDRESS, held_address,
                               held_opcode, payload_len());
               else
                  push_verdict(sfr_pkg::STATUS_OK, sfr_pkg::CAUSE_NONE, held_address,
                               held_opcode, payload_len());
            end
            default: phase = sfr_pkg::PH_HUNT;
         endcase
      endfunction

      function void compare_field(string name, int unsigned e, int unsigned a);
         if (e != a) begin
            errors++;
            if (errors <= 40)
               $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, e, a);
         end
      endfunction

      function void check_rsp(sfr_pkg::rsp_type act);
         sfr_pkg::rsp_type exp;
         if (awaited_results.size() == 0) begin
            errors++;
            if (errors <= 40)
               $display("%0t: unexpected result, expected none, actual %h", $time, act);
            return;
         end
         exp = awaited_results.pop_front();
         if (exp.kind == sfr_pkg::KIND_VERDICT) cause_seen[exp.cause]++;
         else payload_seen++;
         compare_field("kind", exp.kind, act.kind);
         compare_field("data_byte", exp.data_byte, act.data_byte);
         compare_field("byte_index", exp.byte_index, act.byte_index);
         compare_field("status", exp.status, act.status);
         compare_field("cause", exp.cause, act.cause);
         compare_field("frame_address", exp.frame_address, act.frame_address);
         compare_field("opcode", exp.opcode, act.opcode);
         compare_field("data_length", exp.data_length, act.data_length);
      endfunction
   endclass

   logic                            clock;
   logic                            reset;
   logic                            csr_we;
   logic [sfr_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [sfr_pkg::CSR_DATA_W-1:0]  csr_wdata;

   sfr_req_if req_chan();
   sfr_rsp_if rsp_chan();

   serial_frame_receiver_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   frame_scoreboard sb;
   rx_beat_type     tx_beats[$];
   bit              calm = 1'b0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #8_000_000;
      $display("Timeout with %0d results outstanding", sb.awaited_results.size());
      $display("Verification failed");
      $finish;
   end

   // Mostly no gap, some short, a few long.
   function automatic int pick_gap();
      int r;
      if (calm) return 0;
      r = $urandom_range(99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic void queue_beat(sfr_pkg::cmd_type c, logic [7:0] b);
      rx_beat_type v;
      v.cmd  = c;
      v.data = b;
      tx_beats.push_back(v);
   endfunction

   // Frame byte, sometimes preceded by ticks that stay under the timeout or stray events.
   function automatic void queue_rx(logic [7:0] b, int limit);
      if ($urandom_range(9) == 0)
         repeat ($urandom_range(0, limit > 3 ? 3 : limit - 1))
            queue_beat(sfr_pkg::CMD_TICK, 8'($urandom_range(255)));
      if ($urandom_range(39) == 0) queue_beat(sfr_pkg::CMD_TIMEOUT, 8'($urandom_range(255)));
      if ($urandom_range(99) == 0) queue_beat(sfr_pkg::CMD_EXT_SYNC, 8'($urandom_range(255)));
      queue_beat(sfr_pkg::CMD_BYTE, b);
   endfunction

   function automatic void build_frame();
      logic [7:0]       body[$];
      logic [7:0]       addr;
      logic [7:0]       end_val;
      logic [15:0]      len_field;
      logic [15:0]      sum;
      int               n, max_payload, limit, cut, r;
      bit               bad_len, cut_short;
      sfr_pkg::cfg_type c;
      c           = sb.cfg;
      limit       = (c.char_timeout_ticks == 0) ? 1 : c.char_timeout_ticks;
      max_payload = (c.max_frame_length >= sfr_pkg::HEADER_BYTES) ?
                    c.max_frame_length - sfr_pkg::HEADER_BYTES : 0;
      repeat ($urandom_range(0, 2)) queue_beat(sfr_pkg::CMD_BYTE, 8'($urandom_range(255)));
      if ($urandom_range(9) == 0) queue_beat(sfr_pkg::CMD_TIMEOUT, 8'($urandom_range(255)));
      if ($urandom_range(9) == 0) queue_beat(sfr_pkg::CMD_TICK, 8'($urandom_range(255)));
      if ($urandom_range(3) == 0) queue_beat(sfr_pkg::CMD_EXT_SYNC, 8'($urandom_range(255)));
      else queue_beat(sfr_pkg::CMD_BYTE, c.start_byte);

      r = $urandom_range(99);
      if (r < 50) addr = c.own_address;
      else if (r < 70) addr = c.alt_address;
      else addr = 8'($urandom_range(255));

      if ($urandom_range(19) == 0)
         n = $urandom_range(0, max_payload < 300 ? max_payload : 300);
      else
         n = $urandom_range(0, max_payload < 10 ? max_payload : 10);
      len_field = 16'(n + sfr_pkg::HEADER_BYTES);
      bad_len   = (c.max_frame_length < sfr_pkg::HEADER_BYTES);
      if ($urandom_range(9) == 0) begin
         bad_len = 1'b1;
         if (c.max_frame_length != 16'hFFFF && $urandom_range(1))
            len_field = 16'($urandom_range(c.max_frame_length + 1, 65535));
         else
            len_field = 16'($urandom_range(0, sfr_pkg::HEADER_BYTES - 1));
      end

      body.push_back(addr);
      body.push_back(c.big_endian ? len_field[15:8] : len_field[7:0]);
      body.push_back(c.big_endian ? len_field[7:0] : len_field[15:8]);
      sum = 16'(addr) + 16'(len_field[7:0]) + 16'(len_field[15:8]);
      if (!bad_len) begin
         for (int i = 0; i <= n; i++) begin
            body.push_back(8'($urandom_range(255)));
            sum = sum + 16'(body[body.size() - 1]);
         end
         if ($urandom_range(11) == 0) sum = sum ^ 16'(1 << $urandom_range(15));
         body.push_back(c.big_endian ? sum[15:8] : sum[7:0]);
         body.push_back(c.big_endian ? sum[7:0] : sum[15:8]);
         end_val = c.end_byte;
         if ($urandom_range(11) == 0) end_val = end_val ^ 8'($urandom_range(1, 255));
         body.push_back(end_val);
      end

      // Broken frame: cut short, preferably inside the payload.
      cut_short = ($urandom_range(9) == 0);
      if (cut_short) begin
         if (!bad_len && n > 0 && $urandom_range(1)) cut = 4 + $urandom_range(n - 1);
         else cut = $urandom_range(1, body.size() - 1);
         while (body.size() > cut) void'(body.pop_back());
      end
      foreach (body[i]) queue_rx(body[i], limit);
      if (cut_short && limit <= 40)
         repeat (limit) queue_beat(sfr_pkg::CMD_TICK, 8'($urandom_range(255)));
   endfunction

   task automatic send_beat(sfr_pkg::cmd_type c, logic [7:0] b);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.command <= c;
      req_chan.rx_byte <= b;
      do @(posedge clock); while (!req_chan.ready);
      sb.take_rx_beat(c, b);
   endtask

   task automatic send_queued();
      rx_beat_type v;
      while (tx_beats.size() != 0) begin
         v = tx_beats.pop_front();
         send_beat(v.cmd, v.data);
      end
   endtask

   // Forces a bad-length verdict from any phase so the receiver ends up hunting.
   task automatic flush_to_hunt();
      if (sb.phase != sfr_pkg::PH_HUNT) begin
         queue_beat(sfr_pkg::CMD_EXT_SYNC, 8'h00);
         repeat (3) queue_beat(sfr_pkg::CMD_BYTE, 8'h00);
         send_queued();
      end
   endtask

   task automatic wait_idle();
      req_chan.valid <= 1'b0;
      while (sb.awaited_results.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_reg(sfr_pkg::csr_index_type idx, logic [15:0] v);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      sb.apply_csr(idx, v);
   endtask

   task automatic load_cfg(sfr_pkg::cfg_type c);
      write_reg(sfr_pkg::CSR_OWN_ADDRESS, 16'(c.own_address));
      write_reg(sfr_pkg::CSR_ALT_ADDRESS, 16'(c.alt_address));
      write_reg(sfr_pkg::CSR_PORT_KIND, 16'(c.port_kind));
      write_reg(sfr_pkg::CSR_START_BYTE, 16'(c.start_byte));
      write_reg(sfr_pkg::CSR_END_BYTE, 16'(c.end_byte));
      write_reg(sfr_pkg::CSR_MAX_FRAME_LEN, c.max_frame_length);
      write_reg(sfr_pkg::CSR_BIG_ENDIAN, 16'(c.big_endian));
      write_reg(sfr_pkg::CSR_CHAR_TIMEOUT, c.char_timeout_ticks);
      csr_we <= 1'b0;
   endtask

   function automatic sfr_pkg::cfg_type make_cfg(int p);
      sfr_pkg::cfg_type c;
      int               r;
      c.own_address = 8'($urandom_range(255));
      c.alt_address = ($urandom_range(3) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
      c.port_kind   = 1'($urandom_range(1));
      c.start_byte  = 8'($urandom_range(255));
      c.end_byte    = 8'($urandom_range(255));
      c.big_endian  = 1'($urandom_range(1));
      r = $urandom_range(99);
      if (r < 70) c.max_frame_length = 16'($urandom_range(4, 64));
      else if (r < 85) c.max_frame_length = 16'($urandom_range(65535));
      else c.max_frame_length = 16'hFFFF;
      c.char_timeout_ticks = ($urandom_range(1) == 0) ? 16'($urandom_range(2, 12)) :
                             16'($urandom_range(13, 65535));
      case (p)
         1: c = '{own_address: 8'd0, alt_address: 8'd0, port_kind: 1'b0, start_byte: 8'd0,
                  end_byte: 8'd0, max_frame_length: 16'd0, big_endian: 1'b0,
                  char_timeout_ticks: 16'd1};
         2: c = '{own_address: 8'hFF, alt_address: 8'hFF, port_kind: 1'b1,
                  start_byte: 8'hFF, end_byte: 8'hFF, max_frame_length: 16'hFFFF,
                  big_endian: 1'b1, char_timeout_ticks: 16'hFFFF};
         3: begin
            c.alt_address        = 8'($urandom_range(1, 255));
            c.port_kind          = 1'b0;
            c.max_frame_length   = 16'($urandom_range(4, 40));
            c.char_timeout_ticks = 16'd1;
         end
         default: ;
      endcase
      return c;
   endfunction

   initial begin : rsp_sink
      sfr_pkg::rsp_type act;
      int               stall_left;
      stall_left     = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
            act.kind          = rsp_chan.kind;
            act.data_byte     = rsp_chan.data_byte;
            act.byte_index    = rsp_chan.byte_index;
            act.status        = rsp_chan.status;
            act.cause         = rsp_chan.cause;
            act.frame_address = rsp_chan.frame_address;
            act.opcode        = rsp_chan.opcode;
            act.data_length   = rsp_chan.data_length;
            sb.check_rsp(act);
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
            if ($urandom_range(3) == 0) stall_left = pick_gap();
         end
      end
   end

   initial begin
      int target;
      sb = new();
      reset            <= 1'b1;
      csr_we           <= 1'b0;
      csr_index        <= '0;
      csr_wdata        <= '0;
      req_chan.valid   <= 1'b0;
      req_chan.command <= sfr_pkg::CMD_BYTE;
      req_chan.rx_byte <= 8'h00;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed beats under reset settings: start 02, end 03, own address 01.
      queue_beat(sfr_pkg::CMD_TIMEOUT, 8'h00);   // overall timeout while hunting
      queue_beat(sfr_pkg::CMD_TICK, 8'hFF);      // tick while hunting does nothing
      queue_beat(sfr_pkg::CMD_BYTE, 8'hFF);      // non-start byte ignored
      queue_beat(sfr_pkg::CMD_BYTE, 8'h02);
      queue_beat(sfr_pkg::CMD_BYTE, 8'h01);
      queue_beat(sfr_pkg::CMD_BYTE, 8'h05);
      queue_beat(sfr_pkg::CMD_BYTE, 8'h00);
      queue_beat(sfr_pkg::CMD_TIMEOUT, 8'hAA);   // ignored inside a frame
      queue_beat(sfr_pkg::CMD_BYTE, 8'hFF);
      queue_beat(sfr_pkg::CMD_BYTE, 8'h00);
      queue_beat(sfr_pkg::CMD_BYTE, 8'h05);
      queue_beat(sfr_pkg::CMD_BYTE, 8'h01);
      queue_beat(sfr_pkg::CMD_BYTE, 8'h03);      // good frame
      queue_beat(sfr_pkg::CMD_EXT_SYNC, 8'h5A);
      queue_beat(sfr_pkg::CMD_BYTE, 8'h01);
      queue_beat(sfr_pkg::CMD_BYTE, 8'h04);
      queue_beat(sfr_pkg::CMD_BYTE, 8'h00);
      queue_beat(sfr_pkg::CMD_BYTE, 8'h00);      // empty payload, checksum follows
      queue_beat(sfr_pkg::CMD_BYTE, 8'h05);
      queue_beat(sfr_pkg::CMD_BYTE, 8'h00);
      queue_beat(sfr_pkg::CMD_BYTE, 8'hFF);      // wrong end byte
      queue_beat(sfr_pkg::CMD_EXT_SYNC, 8'h00);
      queue_beat(sfr_pkg::CMD_BYTE, 8'h09);
      queue_beat(sfr_pkg::CMD_BYTE, 8'h03);
      queue_beat(sfr_pkg::CMD_BYTE, 8'h00);      // length below header size
      send_queued();

      for (int p = 1; p <= 8; p++) begin
         flush_to_hunt();
         wait_idle();
         load_cfg(make_cfg(p));
         target = sb.beats_in + 155;
         while (sb.beats_in < target) begin
            calm = ($urandom_range(4) == 0);
            build_frame();
            send_queued();
         end
      end
      calm = 1'b0;
      wait_idle();

      $display("Covered %0d input beats over 9 register settings; %0d payload bytes checked",
               sb.beats_in, sb.payload_seen);
      $display("Verdicts: ok %0d, length %0d, data timeout %0d, no end %0d, checksum %0d, %s",
               sb.cause_seen[sfr_pkg::CAUSE_NONE], sb.cause_seen[sfr_pkg::CAUSE_BAD_LEN],
               sb.cause_seen[sfr_pkg::CAUSE_DATA_TMO], sb.cause_seen[sfr_pkg::CAUSE_NO_END],
               sb.cause_seen[sfr_pkg::CAUSE_CHECKSUM],
               $sformatf("address %0d, overall timeout %0d",
                         sb.cause_seen[sfr_pkg::CAUSE_ADDRESS],
                         sb.cause_seen[sfr_pkg::CAUSE_FRAME_TMO]));
      if (sb.errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

@@ sim.f @@
src/sfr_pkg.sv
src/sfr_req_if.sv
src/sfr_rsp_if.sv
src/sfr_csr.sv
src/serial_frame_receiver_top.sv
tb/tb_serial_frame_receiver_top.sv
